FILE: rtl/core/fqid_pkg.sv
`default_nettype none

package fqid_pkg;

	// Queue geometry
	localparam int DEPTH = 16;
	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	// Beat field widths
	localparam int VAL_W  = 32;
	localparam int POS_W  = 4;
	localparam int KIND_W = 2;
	localparam int FILL_W = 5;
	localparam int STAT_W = 2;

	typedef enum logic [KIND_W-1:0] {
		REQ_PUSH   = 2'd0,
		REQ_POP    = 2'd1,
		REQ_READ   = 2'd2,
		REQ_DELETE = 2'd3
	} req_kind_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_RANGE = 2'd2
	} status_t;

	// Decoded request, from the decoder to the entry store
	typedef struct packed {
		logic             push_en;
		logic             take_en;
		logic             rd_en;
		logic [IDX_W-1:0] idx;
		status_t          status;
	} op_t;

endpackage

`default_nettype wire

FILE: rtl/core/fqid_if.sv
`default_nettype none

interface fqid_req_if;
	import fqid_pkg::*;

	logic                    valid;
	logic                    ready;
	logic [KIND_W-1:0]       req_type;
	logic signed [VAL_W-1:0] push_value;
	logic [POS_W-1:0]        position;

	modport source (output valid, req_type, push_value, position, input ready);
	modport sink (input valid, req_type, push_value, position, output ready);
endinterface

interface fqid_rsp_if;
	import fqid_pkg::*;

	logic                    valid;
	logic                    ready;
	logic signed [VAL_W-1:0] out_value;
	logic [FILL_W-1:0]       fill_count;
	logic [STAT_W-1:0]       status;

	modport source (output valid, out_value, fill_count, status, input ready);
	modport sink (input valid, out_value, fill_count, status, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/fqid_decode.sv
`default_nettype none

module fqid_decode
	import fqid_pkg::*;
(
	input  logic [KIND_W-1:0] req_type,
	input  logic [POS_W-1:0]  position,
	input  logic [CNT_W-1:0]  count,
	output op_t               op
);

	req_kind_t kind;
	logic      full;
	logic      empty;
	logic      pos_ok;

	assign kind   = req_kind_t'(req_type);
	assign full   = (count == CNT_W'(DEPTH));
	assign empty  = (count == '0);
	assign pos_ok = (int'(position) < int'(count)) && (int'(position) < DEPTH);

	always_comb begin
		op = '{push_en: 1'b0, take_en: 1'b0, rd_en: 1'b0, idx: '0, status: ST_OK};
		unique case (kind)
			REQ_PUSH: begin
				if (full) begin
					op.status = ST_FULL;
				end else begin
					op.push_en = 1'b1;
				end
			end
			REQ_POP: begin
				if (empty) begin
					op.status = ST_RANGE;
				end else begin
					op.take_en = 1'b1;
					op.rd_en   = 1'b1;
				end
			end
			REQ_READ: begin
				if (!pos_ok) begin
					op.status = ST_RANGE;
				end else begin
					op.rd_en = 1'b1;
					op.idx   = IDX_W'(position);
				end
			end
			REQ_DELETE: begin
				if (!pos_ok) begin
					op.status = ST_RANGE;
				end else begin
					op.take_en = 1'b1;
					op.rd_en   = 1'b1;
					op.idx     = IDX_W'(position);
				end
			end
			default: begin
				op.status = ST_RANGE;
			end
		endcase
	end

endmodule

`default_nettype wire

FILE: rtl/core/fqid_store.sv
`default_nettype none

module fqid_store
	import fqid_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  op_t                     op,
	input  logic signed [VAL_W-1:0] push_value,
	output logic [CNT_W-1:0]        count,
	output logic [CNT_W-1:0]        count_nxt,
	output logic signed [VAL_W-1:0] rd_value
);

	logic [VAL_W-1:0] entry_q [DEPTH];
	logic [CNT_W-1:0] count_q;

	assign count    = count_q;
	assign rd_value = op.rd_en ? signed'(entry_q[op.idx]) : '0;

	always_comb begin
		count_nxt = count_q;
		if (op.push_en) begin
			count_nxt = count_q + CNT_W'(1);
		end else if (op.take_en) begin
			count_nxt = count_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (en) begin
			count_q <= count_nxt;
		end
	end

	// Entries carry no reset; only slots below the count are ever read
	always_ff @(posedge clk) begin
		if (en && op.push_en) begin
			entry_q[count_q[IDX_W-1:0]] <= push_value;
		end else if (en && op.take_en) begin
			for (int i = 0; i < DEPTH - 1; i++) begin
				if (IDX_W'(i) >= op.idx) begin
					entry_q[i] <= entry_q[i + 1];
				end
			end
		end
	end

endmodule

`default_nettype wire

FILE: rtl/core/fifo_queue_indexed_delete.sv
// fifo_queue_indexed_delete: bounded queue of signed 32-bit values, head at
// position 0, with push, pop, indexed read and indexed delete.
// Channels: req (sink) carries req_type, push_value and position; rsp
// (source) carries out_value, fill_count and status. Both are valid/ready;
// a beat moves on a rising edge with valid and ready high.
// Every request beat yields exactly one response beat, registered: the
// response is valid the cycle after the request is taken. Throughput is
// one request per cycle while rsp is not stalled: the whole request is
// decoded and applied to the register array in the cycle it is taken,
// with delete shifting all later entries towards the head in parallel.
// If rsp stalls, the response register holds its beat and req.ready drops
// until it is taken; ready is high whenever the register is empty or is
// being drained in the same cycle.
// Errors (push when full, pop when empty, position past the tail) leave the
// queue untouched and return zero with a status code.
// Reset (arst_n low) empties the queue and the response register; entry
// contents are not cleared.
`default_nettype none

module fifo_queue_indexed_delete
	import fqid_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	fqid_req_if.sink   req,
	fqid_rsp_if.source rsp
);

	op_t                     op;
	logic [CNT_W-1:0]        count;
	logic [CNT_W-1:0]        count_nxt;
	logic signed [VAL_W-1:0] rd_value;
	logic                    take;

	// Response register
	logic                    rsp_valid_q;
	logic signed [VAL_W-1:0] rsp_value_q;
	logic [FILL_W-1:0]       rsp_fill_q;
	status_t                 rsp_status_q;

	// Accept whenever the response slot is free or emptying this cycle
	assign req.ready = !rsp_valid_q || rsp.ready;
	assign take      = req.valid && req.ready;

	fqid_decode u_decode (
		.req_type (req.req_type),
		.position (req.position),
		.count    (count),
		.op       (op)
	);

	fqid_store u_store (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (take),
		.op         (op),
		.push_value (req.push_value),
		.count      (count),
		.count_nxt  (count_nxt),
		.rd_value   (rd_value)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (take) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// Payload: no reset needed, qualified by rsp_valid_q
	always_ff @(posedge clk) begin
		if (take) begin
			rsp_value_q  <= rd_value;
			rsp_fill_q   <= FILL_W'(count_nxt);
			rsp_status_q <= op.status;
		end
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.out_value  = rsp_value_q;
	assign rsp.fill_count = rsp_fill_q;
	assign rsp.status     = rsp_status_q;

endmodule

`default_nettype wire
